### rtl/pob_pkg.sv
// Shared types and codes of the price-time order book.
`timescale 1ns / 1ps
package pob_pkg;

  localparam int PRICE_W = 32;
  localparam int QTY_W   = 31;
  localparam int ID_W    = 31;
  localparam int ARR_W   = 32;

  typedef enum logic [2:0] {
    FN_ADD    = 3'd0,
    FN_CANCEL = 3'd1,
    FN_SETQ   = 3'd2,
    FN_POP    = 3'd3,
    FN_QUERY  = 3'd4
  } func_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NOT_FND  = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_FULL     = 3'd3,
    ST_DUP      = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    OS_NONE      = 3'd0,
    OS_RESTING   = 3'd1,
    OS_PARTIAL   = 3'd2,
    OS_FILLED    = 3'd3,
    OS_CANCELLED = 3'd4
  } ostate_e;

  // one slot of the book table
  typedef struct packed {
    logic               side;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
    logic [ID_W-1:0]    ident;
    logic [ARR_W-1:0]   arrival;
  } entry_t;

  // latched request
  typedef struct packed {
    logic [2:0]         func;
    logic               side;
    logic [ID_W-1:0]    ord_id;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   quantity;
  } req_t;

  // best order of one side found by a scan
  typedef struct packed {
    logic               hit;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
    logic [ID_W-1:0]    ident;
    logic [ARR_W-1:0]   arrival;
  } best_t;

  // what a scan reports back to the sequencer, apart from slot indices and the query sum
  typedef struct packed {
    logic   id_hit;
    entry_t id_entry;
    logic   free_hit;
    best_t  bid;
    best_t  ask;
    logic   any_side;
    logic   any_elig;
  } scan_res_t;

endpackage

### rtl/pob_if.sv
// Request and result channel interfaces of the order book.
`timescale 1ns / 1ps
interface pob_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic        side;
  logic [30:0] ord_id;
  logic [31:0] price;
  logic [30:0] quantity;

  modport source (output valid, func, side, ord_id, price, quantity, input ready);
  modport sink   (input valid, func, side, ord_id, price, quantity, output ready);
endinterface

interface pob_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        fill_possible;
  logic [2:0]  order_state;
  logic        best_bid_valid;
  logic [31:0] best_bid_price;
  logic [30:0] best_bid_qty;
  logic [30:0] best_bid_id;
  logic        best_ask_valid;
  logic [31:0] best_ask_price;
  logic [30:0] best_ask_qty;
  logic [30:0] best_ask_id;

  modport source (output valid, status, fill_possible, order_state,
                  best_bid_valid, best_bid_price, best_bid_qty, best_bid_id,
                  best_ask_valid, best_ask_price, best_ask_qty, best_ask_id,
                  input ready);
  modport sink   (input valid, status, fill_possible, order_state,
                  best_bid_valid, best_bid_price, best_bid_qty, best_bid_id,
                  best_ask_valid, best_ask_price, best_ask_qty, best_ask_id,
                  output ready);
endinterface

### rtl/pob_table.sv
// Order table: slot memory with one write and one registered read port, plus valid bits.
`timescale 1ns / 1ps
module pob_table import pob_pkg::*; #(
  parameter int Depth = 128,
  parameter int AW    = 7
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_idx_i,
  input  entry_t        wr_entry_i,
  input  logic          vld_we_i,
  input  logic [AW-1:0] vld_idx_i,
  input  logic          vld_bit_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_idx_i,
  output entry_t        rd_entry_o,
  output logic          rd_valid_o
);

  entry_t           mem_q [Depth];
  entry_t           rd_entry_q;
  logic [Depth-1:0] valid_q;
  logic             rd_valid_q;

  // slot memory
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_idx_i] <= wr_entry_i;
    end
    if (rd_en_i) begin
      rd_entry_q <= mem_q[rd_idx_i];
    end
  end

  // valid bits, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (vld_we_i) begin
        valid_q[vld_idx_i] <= vld_bit_i;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_idx_i];
      end
    end
  end

  assign rd_entry_o = rd_entry_q;
  assign rd_valid_o = rd_valid_q;

endmodule

### rtl/pob_scan.sv
// Scan unit: folds one word per beat_i cycle into id match, free slot, best per side, query sum.
`timescale 1ns / 1ps
module pob_scan import pob_pkg::*; #(
  parameter int AW = 7,
  parameter int SW = 39
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               clr_i,
  input  logic               beat_i,
  input  logic [AW-1:0]      idx_i,
  input  entry_t             entry_i,
  input  logic               valid_i,
  input  logic               side_i,
  input  logic [ID_W-1:0]    id_i,
  input  logic [PRICE_W-1:0] limit_i,
  output scan_res_t          res_o,
  output logic [AW-1:0]      id_idx_o,
  output logic [AW-1:0]      free_idx_o,
  output logic [AW-1:0]      bid_idx_o,
  output logic [AW-1:0]      ask_idx_o,
  output logic [SW-1:0]      sum_o
);

  scan_res_t     res_q;
  logic [AW-1:0] id_idx_q, free_idx_q, bid_idx_q, ask_idx_q;
  logic [SW-1:0] sum_q;
  best_t         cur;
  best_t         cand;
  logic          ahead;
  logic          elig;

  // compare the incoming word against the best of its side
  always_comb begin
    cur  = entry_i.side ? res_q.ask : res_q.bid;
    cand = '{hit: 1'b1, price: entry_i.price, qty: entry_i.qty,
             ident: entry_i.ident, arrival: entry_i.arrival};
    if (!cur.hit) begin
      ahead = 1'b1;
    end else if (entry_i.price != cur.price) begin
      ahead = entry_i.side ? (entry_i.price < cur.price) : (entry_i.price > cur.price);
    end else begin
      // equal arrival keeps the lower slot, which was seen first
      ahead = entry_i.arrival < cur.arrival;
    end
    elig = side_i ? (entry_i.price <= limit_i) : (entry_i.price >= limit_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
      sum_q <= '0;
    end else if (clr_i) begin
      res_q <= '0;
      sum_q <= '0;
    end else if (beat_i) begin
      // first valid slot with the id
      if (valid_i && !res_q.id_hit && entry_i.ident == id_i) begin
        res_q.id_hit   <= 1'b1;
        res_q.id_entry <= entry_i;
        id_idx_q       <= idx_i;
      end
      // lowest free slot
      if (!valid_i && !res_q.free_hit) begin
        res_q.free_hit <= 1'b1;
        free_idx_q     <= idx_i;
      end
      // best per side
      if (valid_i && ahead) begin
        if (entry_i.side) begin
          res_q.ask <= cand;
          ask_idx_q <= idx_i;
        end else begin
          res_q.bid <= cand;
          bid_idx_q <= idx_i;
        end
      end
      // query accumulation on the requested side
      if (valid_i && entry_i.side == side_i) begin
        res_q.any_side <= 1'b1;
        if (elig) begin
          res_q.any_elig <= 1'b1;
          sum_q          <= sum_q + SW'(entry_i.qty);
        end
      end
    end
  end

  assign res_o      = res_q;
  assign id_idx_o   = id_idx_q;
  assign free_idx_o = free_idx_q;
  assign bid_idx_o  = bid_idx_q;
  assign ask_idx_o  = ask_idx_q;
  assign sum_o      = sum_q;

endmodule

### rtl/price_time_order_book_top.sv
// Price-time order book: sequencer over the slot table and the shared scan unit.
// Each request runs a table scan for id, free slot, best orders and query sum, the
// update state, and a second scan for the best bid and ask; a new request is taken
// only after the result word is accepted, since ready is high only while idle.
// Reset clears valid bits, arrival counter and control; slot contents stay unwritten.
`timescale 1ns / 1ps
module price_time_order_book_top import pob_pkg::*; #(
  parameter int BOOK_DEPTH = 128
) (
  input  logic clk_i,
  input  logic rst_ni,
  pob_req_if.sink   req_i,
  pob_rsp_if.source rsp_o
);

  localparam int AW = $clog2(BOOK_DEPTH);
  localparam int CW = $clog2(BOOK_DEPTH + 1);
  localparam int SW = QTY_W + AW + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY,
    S_RESP
  } state_e;

  state_e          state_q;
  logic            pass_q;
  logic [CW-1:0]   cnt_q;
  logic            beat_q;
  logic [AW-1:0]   beat_idx_q;
  req_t            req_q;
  logic [ARR_W-1:0] arr_q;
  status_e         status_q, status_d;
  ostate_e         ostate_q, ostate_d;
  logic            fill_q, fill_d;
  best_t           bid_q, ask_q;
  logic            rsp_valid_q;

  logic            rd_en;
  logic            scan_done;
  logic            scan_clr;
  logic            tbl_we;
  logic [AW-1:0]   tbl_widx;
  entry_t          tbl_wentry;
  logic            vld_we;
  logic [AW-1:0]   vld_idx;
  logic            vld_bit;
  logic            arr_inc;
  entry_t          rd_entry;
  logic            rd_valid;
  scan_res_t       res;
  logic [AW-1:0]   id_idx, free_idx, bid_idx, ask_idx;
  logic [SW-1:0]   sum;

  pob_table #(.Depth(BOOK_DEPTH), .AW(AW)) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (tbl_we),
    .wr_idx_i   (tbl_widx),
    .wr_entry_i (tbl_wentry),
    .vld_we_i   (vld_we),
    .vld_idx_i  (vld_idx),
    .vld_bit_i  (vld_bit),
    .rd_en_i    (rd_en),
    .rd_idx_i   (cnt_q[AW-1:0]),
    .rd_entry_o (rd_entry),
    .rd_valid_o (rd_valid)
  );

  pob_scan #(.AW(AW), .SW(SW)) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clr_i      (scan_clr),
    .beat_i     (beat_q),
    .idx_i      (beat_idx_q),
    .entry_i    (rd_entry),
    .valid_i    (rd_valid),
    .side_i     (req_q.side),
    .id_i       (req_q.ord_id),
    .limit_i    (req_q.price),
    .res_o      (res),
    .id_idx_o   (id_idx),
    .free_idx_o (free_idx),
    .bid_idx_o  (bid_idx),
    .ask_idx_o  (ask_idx),
    .sum_o      (sum)
  );

  // scan control
  assign rd_en     = (state_q == S_SCAN) && (cnt_q != CW'(BOOK_DEPTH));
  assign scan_done = (state_q == S_SCAN) && (cnt_q == CW'(BOOK_DEPTH)) && !beat_q;
  assign scan_clr  = ((state_q == S_IDLE) && req_i.valid) || (state_q == S_APPLY);

  // update decision after the first scan
  always_comb begin
    tbl_we     = 1'b0;
    tbl_widx   = id_idx;
    tbl_wentry = res.id_entry;
    vld_we     = 1'b0;
    vld_idx    = id_idx;
    vld_bit    = 1'b0;
    arr_inc    = 1'b0;
    status_d   = ST_OK;
    ostate_d   = OS_NONE;
    fill_d     = 1'b0;
    if (state_q == S_APPLY) begin
      unique case (func_e'(req_q.func))
        FN_ADD: begin
          if (res.id_hit) begin
            status_d = ST_DUP;
          end else if (!res.free_hit) begin
            status_d = ST_FULL;
          end else begin
            tbl_we     = 1'b1;
            tbl_widx   = free_idx;
            tbl_wentry = '{side: req_q.side, price: req_q.price, qty: req_q.quantity,
                           ident: req_q.ord_id, arrival: arr_q};
            vld_we     = 1'b1;
            vld_idx    = free_idx;
            vld_bit    = 1'b1;
            arr_inc    = 1'b1;
            ostate_d   = OS_RESTING;
          end
        end
        FN_CANCEL: begin
          if (!res.id_hit) begin
            status_d = ST_NOT_FND;
          end else begin
            vld_we   = 1'b1;
            ostate_d = OS_CANCELLED;
          end
        end
        FN_SETQ: begin
          if (!res.id_hit) begin
            status_d = ST_NOT_FND;
          end else if (req_q.quantity != '0) begin
            tbl_we         = 1'b1;
            tbl_wentry.qty = req_q.quantity;
            ostate_d       = OS_PARTIAL;
          end else begin
            vld_we   = 1'b1;
            ostate_d = OS_FILLED;
          end
        end
        FN_POP: begin
          if (req_q.side ? !res.ask.hit : !res.bid.hit) begin
            status_d = ST_EMPTY;
          end else begin
            vld_we   = 1'b1;
            vld_idx  = req_q.side ? ask_idx : bid_idx;
            ostate_d = OS_FILLED;
          end
        end
        FN_QUERY: begin
          if (!res.any_side) begin
            status_d = ST_EMPTY;
          end else begin
            fill_d = res.any_elig && (sum >= SW'(req_q.quantity));
          end
        end
        default: begin
        end
      endcase
    end
  end

  // sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pass_q      <= 1'b0;
      cnt_q       <= '0;
      beat_q      <= 1'b0;
      arr_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      beat_q <= rd_en;
      if (rd_en) begin
        beat_idx_q <= cnt_q[AW-1:0];
        cnt_q      <= cnt_q + CW'(1);
      end
      unique case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            req_q   <= '{func: req_i.func, side: req_i.side, ord_id: req_i.ord_id,
                         price: req_i.price, quantity: req_i.quantity};
            pass_q  <= 1'b0;
            cnt_q   <= '0;
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_done) begin
            if (pass_q) begin
              bid_q       <= res.bid;
              ask_q       <= res.ask;
              rsp_valid_q <= 1'b1;
              state_q     <= S_RESP;
            end else begin
              state_q <= S_APPLY;
            end
          end
        end
        S_APPLY: begin
          status_q <= status_d;
          ostate_q <= ostate_d;
          fill_q   <= fill_d;
          if (arr_inc) begin
            arr_q <= arr_q + ARR_W'(1);
          end
          pass_q  <= 1'b1;
          cnt_q   <= '0;
          state_q <= S_SCAN;
        end
        S_RESP: begin
          if (rsp_o.ready) begin
            rsp_valid_q <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // ports; an empty side reports zeros
  assign req_i.ready          = (state_q == S_IDLE);
  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.status         = status_q;
  assign rsp_o.fill_possible  = fill_q;
  assign rsp_o.order_state    = ostate_q;
  assign rsp_o.best_bid_valid = bid_q.hit;
  assign rsp_o.best_bid_price = bid_q.hit ? bid_q.price : '0;
  assign rsp_o.best_bid_qty   = bid_q.hit ? bid_q.qty : '0;
  assign rsp_o.best_bid_id    = bid_q.hit ? bid_q.ident : '0;
  assign rsp_o.best_ask_valid = ask_q.hit;
  assign rsp_o.best_ask_price = ask_q.hit ? ask_q.price : '0;
  assign rsp_o.best_ask_qty   = ask_q.hit ? ask_q.qty : '0;
  assign rsp_o.best_ask_id    = ask_q.hit ? ask_q.ident : '0;

endmodule

### tb/sv/pob_tb_if.sv
// Testbench-side note: interfaces come from the RTL; this file holds the order book predictor.
`timescale 1ns / 1ps
package pob_tb_pkg;
  import pob_pkg::*;

  localparam int DEPTH = 128;

  // one request word
  typedef struct packed {
    logic [2:0]  func;
    logic        side;
    logic [30:0] ord_id;
    logic [31:0] price;
    logic [30:0] quantity;
  } request_t;

  // one result word
  typedef struct packed {
    logic [2:0]  status;
    logic        fill_possible;
    logic [2:0]  order_state;
    logic        bid_valid;
    logic [31:0] bid_price;
    logic [30:0] bid_qty;
    logic [30:0] bid_id;
    logic        ask_valid;
    logic [31:0] ask_price;
    logic [30:0] ask_qty;
    logic [30:0] ask_id;
  } result_t;

  class book_scoreboard;
    bit          live[DEPTH];
    bit          slot_side[DEPTH];
    logic [31:0] slot_price[DEPTH];
    logic [30:0] slot_qty[DEPTH];
    logic [30:0] slot_id[DEPTH];
    logic [31:0] slot_arr[DEPTH];
    logic [31:0] arrivals;
    result_t     pending[$];
    int          errors;

    function new();
      arrivals = 0;
      errors = 0;
      foreach (live[i]) live[i] = 0;
    endfunction

    function bit ahead(int a, int b);
      if (slot_price[a] != slot_price[b])
        return slot_side[a] == 0 ? slot_price[a] > slot_price[b]
                                 : slot_price[a] < slot_price[b];
      if (slot_arr[a] != slot_arr[b]) return slot_arr[a] < slot_arr[b];
      return a < b;
    endfunction

    function int best_slot(bit sd);
      int b;
      b = -1;
      for (int i = 0; i < DEPTH; i++)
        if (live[i] && slot_side[i] == sd && (b < 0 || ahead(i, b))) b = i;
      return b;
    endfunction

    function int find_order(logic [30:0] id);
      for (int i = 0; i < DEPTH; i++)
        if (live[i] && slot_id[i] == id) return i;
      return -1;
    endfunction

    function int occupancy();
      int n;
      n = 0;
      foreach (live[i]) n += live[i];
      return n;
    endfunction

    // apply one accepted request and queue its expected result
    function void note_request(request_t rq);
      result_t r;
      int s;
      longint unsigned sum;
      bit any_side, any_elig;
      r = '{default: '0};
      case (rq.func)
        FN_ADD: begin
          if (find_order(rq.ord_id) >= 0) r.status = ST_DUP;
          else begin
            s = -1;
            for (int i = DEPTH - 1; i >= 0; i--) if (!live[i]) s = i;
            if (s < 0) r.status = ST_FULL;
            else begin
              live[s] = 1; slot_side[s] = rq.side; slot_price[s] = rq.price;
              slot_qty[s] = rq.quantity; slot_id[s] = rq.ord_id;
              slot_arr[s] = arrivals; arrivals++;
              r.order_state = OS_RESTING;
            end
          end
        end
        FN_CANCEL: begin
          s = find_order(rq.ord_id);
          if (s < 0) r.status = ST_NOT_FND;
          else begin live[s] = 0; r.order_state = OS_CANCELLED; end
        end
        FN_SETQ: begin
          s = find_order(rq.ord_id);
          if (s < 0) r.status = ST_NOT_FND;
          else if (rq.quantity != 0) begin
            slot_qty[s] = rq.quantity; r.order_state = OS_PARTIAL;
          end else begin
            slot_qty[s] = 0; live[s] = 0; r.order_state = OS_FILLED;
          end
        end
        FN_POP: begin
          s = best_slot(rq.side);
          if (s < 0) r.status = ST_EMPTY;
          else begin live[s] = 0; r.order_state = OS_FILLED; end
        end
        FN_QUERY: begin
          sum = 0; any_side = 0; any_elig = 0;
          for (int i = 0; i < DEPTH; i++)
            if (live[i] && slot_side[i] == rq.side) begin
              any_side = 1;
              if (rq.side == 0 ? slot_price[i] >= rq.price : slot_price[i] <= rq.price) begin
                any_elig = 1; sum += slot_qty[i];
              end
            end
          if (!any_side) r.status = ST_EMPTY;
          else if (any_elig && sum >= rq.quantity) r.fill_possible = 1;
        end
        default: ;
      endcase
      s = best_slot(0);
      if (s >= 0) begin
        r.bid_valid = 1; r.bid_price = slot_price[s];
        r.bid_qty = slot_qty[s]; r.bid_id = slot_id[s];
      end
      s = best_slot(1);
      if (s >= 0) begin
        r.ask_valid = 1; r.ask_price = slot_price[s];
        r.ask_qty = slot_qty[s]; r.ask_id = slot_id[s];
      end
      pending.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result word, status %0d", $time, got.status);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (exp !== got) begin
        $display("%0t: expected st=%0d fill=%0d os=%0d bid=%0d/%h/%h/%h ask=%0d/%h/%h/%h",
                 $time, exp.status, exp.fill_possible, exp.order_state, exp.bid_valid,
                 exp.bid_price, exp.bid_qty, exp.bid_id, exp.ask_valid, exp.ask_price,
                 exp.ask_qty, exp.ask_id);
        $display("%0t: actual   st=%0d fill=%0d os=%0d bid=%0d/%h/%h/%h ask=%0d/%h/%h/%h",
                 $time, got.status, got.fill_possible, got.order_state, got.bid_valid,
                 got.bid_price, got.bid_qty, got.bid_id, got.ask_valid, got.ask_price,
                 got.ask_qty, got.ask_id);
        errors++;
      end
    endfunction
  endclass
endpackage

### tb/sv/price_time_order_book_top_tb.sv
// Testbench top: drives directed and random order book requests and checks every result word.
`timescale 1ns / 1ps
module price_time_order_book_top_tb;
  import pob_pkg::*;
  import pob_tb_pkg::*;

  logic clk_i = 0;
  logic rst_ni = 0;
  pob_req_if req_if ();
  pob_rsp_if rsp_if ();

  price_time_order_book_top u_dut (
    .clk_i (clk_i), .rst_ni (rst_ni), .req_i (req_if.sink), .rsp_o (rsp_if.source)
  );

  always #10 clk_i = ~clk_i;

  book_scoreboard sb = new();
  logic [30:0] used_ids[$];
  bit          quiet = 0;     // no idling in the last part
  bit          hold_long = 0; // request for a long receiver stall

  initial begin
    req_if.valid = 0; req_if.func = 0; req_if.side = 0;
    req_if.ord_id = 0; req_if.price = 0; req_if.quantity = 0;
    rsp_if.ready = 0;
  end

  // send one word and note it once accepted
  task automatic send(logic [2:0] f, logic sd, logic [30:0] id, logic [31:0] pr,
                      logic [30:0] q);
    request_t rq;
    rq.func = f; rq.side = sd; rq.ord_id = id; rq.price = pr; rq.quantity = q;
    req_if.valid <= 1; req_if.func <= f; req_if.side <= sd;
    req_if.ord_id <= id; req_if.price <= pr; req_if.quantity <= q;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_request(rq);
    if (f == FN_ADD) used_ids.push_back(id);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
  endtask

  // the block is busy right after an accept, so dropping valid late here is safe
  task automatic drain();
    @(posedge clk_i);
    req_if.valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [30:0] pick_id();
    if (used_ids.size() != 0 && $urandom_range(0, 3) != 0)
      return used_ids[$urandom_range(0, used_ids.size() - 1)];
    return $urandom_range(0, 63) == 0 ? 31'h7fffffff : 31'($urandom());
  endfunction

  // random word, mostly well formed around a narrow price band
  task automatic random_item();
    logic [2:0] f;
    logic [31:0] pr;
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) f = FN_ADD;
    else if (r < 52) f = FN_CANCEL;
    else if (r < 64) f = FN_SETQ;
    else if (r < 76) f = FN_POP;
    else if (r < 96) f = FN_QUERY;
    else f = 3'($urandom_range(5, 7));
    pr = ($urandom_range(0, 9) == 0) ? $urandom() : 32'(1000 + $urandom_range(0, 20));
    send(f, 1'($urandom_range(0, 1)), pick_id(), pr,
         $urandom_range(0, 7) == 0 ? 31'($urandom()) : 31'($urandom_range(0, 500)));
  endtask

  // stimulus
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed: empty book, extremes, all operations
    send(FN_POP, 0, 0, 0, 0);
    send(FN_QUERY, 1, 0, 0, 0);
    send(FN_CANCEL, 0, 5, 0, 0);
    send(FN_SETQ, 0, 5, 0, 3);
    send(FN_ADD, 0, 1, 32'hffffffff, 31'h7fffffff);
    send(FN_ADD, 0, 2, 32'hffffffff, 0);
    send(FN_ADD, 1, 3, 0, 31'h7fffffff);
    send(FN_ADD, 1, 31'h7fffffff, 0, 7);
    send(FN_ADD, 1, 1, 5, 5);
    send(FN_QUERY, 0, 0, 32'hffffffff, 0);
    send(FN_QUERY, 1, 0, 0, 31'h7fffffff);
    send(FN_QUERY, 0, 0, 0, 31'h7fffffff);
    send(FN_SETQ, 1, 1, 0, 31'h7fffffff);
    send(FN_SETQ, 1, 2, 0, 0);
    send(3'd5, 0, 0, 0, 0);
    send(3'd7, 1, 31'h7fffffff, 32'hffffffff, 31'h7fffffff);
    send(FN_POP, 0, 0, 0, 0);
    send(FN_POP, 1, 0, 0, 0);
    send(FN_CANCEL, 1, 31'h7fffffff, 0, 0);
    send(FN_QUERY, 1, 0, 32'hffffffff, 1);
    drain();
    // fill the book, overflow, then empty it by pops
    for (int i = 0; i < DEPTH + 2; i++)
      send(FN_ADD, i[0], 31'(10000 + i), 32'(500 + $urandom_range(0, 3)), 31'(i));
    hold_long = 1;
    send(FN_ADD, 0, 31'h7ffffffe, 0, 0);
    for (int i = 0; i < 8; i++) send(FN_QUERY, i[0], 0, 501, 31'(i * 100));
    hold_long = 0;
    drain();
    for (int i = 0; i < DEPTH + 2; i++) send(FN_POP, 1'($urandom_range(0, 1)), 0, 0, 0);
    used_ids.delete();
    drain();
    // random
    for (int n = 0; n < 260; n++) begin
      if (n == 200) quiet = 1;
      random_item();
    end
    drain();
    repeat (300) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("price_time_order_book_top: match");
    else $display("price_time_order_book_top: mismatch");
    $finish;
  end

  // result side: random stalls, one long hold-off
  initial begin
    result_t got;
    bit      held;
    held = 0;
    @(posedge rst_ni);
    forever begin
      if (hold_long && !held) begin
        held = 1;
        rsp_if.ready <= 0;
        repeat (1500) @(posedge clk_i);
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        rsp_if.ready <= 0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
      rsp_if.ready <= 1;
      @(posedge clk_i);
      if (rsp_if.valid && rsp_if.ready) begin
        got.status = rsp_if.status; got.fill_possible = rsp_if.fill_possible;
        got.order_state = rsp_if.order_state;
        got.bid_valid = rsp_if.best_bid_valid; got.bid_price = rsp_if.best_bid_price;
        got.bid_qty = rsp_if.best_bid_qty; got.bid_id = rsp_if.best_bid_id;
        got.ask_valid = rsp_if.best_ask_valid; got.ask_price = rsp_if.best_ask_price;
        got.ask_qty = rsp_if.best_ask_qty; got.ask_id = rsp_if.best_ask_id;
        sb.check_result(got);
      end
    end
  end

  // timeout
  initial begin
    #(64'd20 * 64'd1_500_000);
    $display("price_time_order_book_top: mismatch");
    $finish;
  end
endmodule

### filelist.f
rtl/pob_pkg.sv
rtl/pob_if.sv
rtl/pob_table.sv
rtl/pob_scan.sv
rtl/price_time_order_book_top.sv
tb/sv/pob_tb_if.sv
tb/sv/price_time_order_book_top_tb.sv
